// File: hw/rtl/ifcc_pkg.sv
`timescale 1ns / 1ps

package ifcc_pkg;

  // byte counter width; the counter saturates at its all-ones value
  localparam int LENGTH_BITS = 32;

  // largest count that still fits the 32-bit length report
  localparam logic [LENGTH_BITS-1:0] LEN_CAP = LENGTH_BITS'(32'hFFFF_FFFF);

  // format codes
  localparam logic [1:0] FMT_UNKNOWN = 2'd0;
  localparam logic [1:0] FMT_PNG     = 2'd1;
  localparam logic [1:0] FMT_BMP     = 2'd2;
  localparam logic [1:0] FMT_JPEG    = 2'd3;

  // header candidate bits
  localparam int ALIVE_PNG  = 0;
  localparam int ALIVE_BMP  = 1;
  localparam int ALIVE_JPEG = 2;

  // header and trailer bytes
  localparam logic [7:0]  BMP_B0    = 8'd66;
  localparam logic [7:0]  BMP_B1    = 8'd77;
  localparam logic [7:0]  JPEG_B0   = 8'd255;
  localparam logic [7:0]  JPEG_B1   = 8'd216;
  localparam logic [39:0] PNG_TAIL  = 40'h44_AE_42_60_82;
  localparam logic [15:0] JPEG_TAIL = 16'hFF_D9;

  // configuration registers
  localparam logic       REG_MIN_LENGTH = 1'b0;
  localparam logic [7:0] MIN_LEN_RESET  = 8'd20;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } word_t;

  typedef struct packed {
    logic        complete;
    logic [1:0]  format;
    logic [31:0] file_length;
  } result_t;

  // png signature byte at header position
  function automatic logic [7:0] png_sig(input logic [2:0] pos);
    logic [7:0] sig;
    case (pos)
      3'd0:    sig = 8'd137;
      3'd1:    sig = 8'd80;
      3'd2:    sig = 8'd78;
      3'd3:    sig = 8'd71;
      3'd4:    sig = 8'd13;
      3'd5:    sig = 8'd10;
      3'd6:    sig = 8'd26;
      3'd7:    sig = 8'd10;
      default: sig = 8'd0;
    endcase
    return sig;
  endfunction

endpackage

// File: hw/rtl/ifcc_in_stage.sv
`timescale 1ns / 1ps

module ifcc_in_stage
  import ifcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_data,
  input  logic       in_last,
  output logic       in_stall,
  input  logic       go,
  output logic       s1_valid,
  output word_t      s1_word
);

  assign in_stall = s1_valid && !go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_word.data <= in_data;
      s1_word.last <= in_last;
    end
  end

endmodule

// File: hw/rtl/ifcc_track.sv
`timescale 1ns / 1ps

module ifcc_track
  import ifcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s1_valid,
  input  word_t      s1_word,
  input  logic       out_free,
  input  logic [7:0] min_length,
  output logic       go,
  output logic       res_valid,
  output result_t    res
);

  logic [LENGTH_BITS-1:0] byte_count, byte_count_next;
  logic [31:0]            recent_bytes, recent_bytes_next;
  logic [1:0]             header_class, header_class_next;
  logic [2:0]             header_alive, header_alive_next;
  logic [31:0]            declared_length, declared_length_next;
  logic [LENGTH_BITS-1:0] png_pos, png_pos_next;
  logic                   png_seen, png_seen_next;
  logic [LENGTH_BITS-1:0] jpeg_pos, jpeg_pos_next;
  logic                   jpeg_seen, jpeg_seen_next;

  logic [7:0]             b;
  logic [LENGTH_BITS-1:0] idx;
  logic [39:0]            tail;
  logic [1:0]             sel;
  logic [LENGTH_BITS-1:0] half;
  logic [LENGTH_BITS:0]   jpeg_min;
  logic                   ok;

  // non-final bytes never wait on the result side
  assign go        = s1_valid && (!s1_word.last || out_free);
  assign res_valid = go && s1_word.last;

  assign b    = s1_word.data;
  assign idx  = byte_count;
  assign tail = {recent_bytes, b};
  assign sel  = idx[1:0] - 2'd2;

  always_comb begin
    header_alive_next    = header_alive;
    header_class_next    = header_class;
    declared_length_next = declared_length;
    png_pos_next         = png_pos;
    png_seen_next        = png_seen;
    jpeg_pos_next        = jpeg_pos;
    jpeg_seen_next       = jpeg_seen;

    // header classification
    if (idx < LENGTH_BITS'(8) && b != png_sig(idx[2:0])) begin
      header_alive_next[ALIVE_PNG] = 1'b0;
    end
    if (idx == '0) begin
      if (b != BMP_B0) header_alive_next[ALIVE_BMP] = 1'b0;
      if (b != JPEG_B0) header_alive_next[ALIVE_JPEG] = 1'b0;
    end else if (idx == LENGTH_BITS'(1)) begin
      if (b != BMP_B1) header_alive_next[ALIVE_BMP] = 1'b0;
      if (b != JPEG_B1) header_alive_next[ALIVE_JPEG] = 1'b0;
      if (header_alive_next[ALIVE_BMP]) begin
        header_class_next = FMT_BMP;
      end else if (header_alive_next[ALIVE_JPEG]) begin
        header_class_next = FMT_JPEG;
      end
    end else if (idx == LENGTH_BITS'(7)) begin
      if (header_alive_next[ALIVE_PNG]) header_class_next = FMT_PNG;
    end

    // bmp size field, little endian at bytes 2..5
    if (idx >= LENGTH_BITS'(2) && idx <= LENGTH_BITS'(5)) begin
      case (sel)
        2'd0:    declared_length_next[7:0]   = declared_length[7:0]   | b;
        2'd1:    declared_length_next[15:8]  = declared_length[15:8]  | b;
        2'd2:    declared_length_next[23:16] = declared_length[23:16] | b;
        2'd3:    declared_length_next[31:24] = declared_length[31:24] | b;
        default: declared_length_next = declared_length;
      endcase
    end

    // trailer detectors
    if (idx >= LENGTH_BITS'(4) && tail == PNG_TAIL) begin
      png_seen_next = 1'b1;
      png_pos_next  = idx;
    end
    if (idx >= LENGTH_BITS'(1) && tail[15:0] == JPEG_TAIL) begin
      jpeg_seen_next = 1'b1;
      jpeg_pos_next  = idx;
    end
  end

  assign recent_bytes_next = tail[31:0];
  assign byte_count_next   = (byte_count != '1) ? byte_count + 1'b1 : byte_count;

  // judgement on the updated length
  assign half     = byte_count_next >> 1;
  assign jpeg_min = {1'b0, half} + (LENGTH_BITS+1)'(2);

  always_comb begin
    ok = 1'b0;
    if (byte_count_next >= LENGTH_BITS'(min_length)) begin
      case (header_class_next)
        FMT_PNG:  ok = png_seen_next && (png_pos_next >= half);
        FMT_BMP:  ok = (LENGTH_BITS+32)'(declared_length_next) <=
                       (LENGTH_BITS+32)'(byte_count_next);
        FMT_JPEG: ok = jpeg_seen_next &&
                       ((jpeg_pos_next == byte_count_next - 1'b1) ||
                        ({1'b0, jpeg_pos_next} >= jpeg_min));
        default:  ok = 1'b0;
      endcase
    end
  end

  assign res.complete    = ok;
  assign res.format      = header_class_next;
  assign res.file_length = (byte_count_next > LEN_CAP) ? 32'hFFFF_FFFF
                                                       : 32'(byte_count_next);

  always_ff @(posedge clk) begin
    if (rst || res_valid) begin
      byte_count      <= '0;
      recent_bytes    <= '0;
      header_class    <= FMT_UNKNOWN;
      header_alive    <= 3'b111;
      declared_length <= '0;
      png_pos         <= '0;
      png_seen        <= 1'b0;
      jpeg_pos        <= '0;
      jpeg_seen       <= 1'b0;
    end else if (go) begin
      byte_count      <= byte_count_next;
      recent_bytes    <= recent_bytes_next;
      header_class    <= header_class_next;
      header_alive    <= header_alive_next;
      declared_length <= declared_length_next;
      png_pos         <= png_pos_next;
      png_seen        <= png_seen_next;
      jpeg_pos        <= jpeg_pos_next;
      jpeg_seen       <= jpeg_seen_next;
    end
  end

endmodule

// File: hw/rtl/ifcc_out_stage.sv
`timescale 1ns / 1ps

module ifcc_out_stage
  import ifcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        res_valid,
  input  result_t     res,
  output logic        out_free,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        complete,
  output logic [1:0]  format,
  output logic [31:0] file_length
);

  result_t held;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      held <= res;
    end
  end

  assign complete    = held.complete;
  assign format      = held.format;
  assign file_length = held.file_length;

endmodule

// File: hw/rtl/image_file_completeness_check.sv
`timescale 1ns / 1ps

// a final byte passes the input register, then the result register, to its result word;
// bytes that are not final give no result word; the single-pass tracker between the two registers sets the rate
// throughput: one byte per cycle unless a final byte waits on a full result register
// reset (rst, synchronous): clears the file state and both stages, min_length returns to 20
module image_file_completeness_check
  import ifcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // byte stream
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  // result stream
  output logic        out_valid,
  input  logic        out_stall,
  output logic        complete,
  output logic [1:0]  format,
  output logic [31:0] file_length,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       min_length;
  logic [7:0] min_len;
  logic       s1_valid;
  word_t      s1_word;
  logic       go;
  logic       out_free;
  logic       res_valid;
  result_t    res;

  // ---------------------------------------------------------------------------
  // configuration: one register, min_length, at byte address 0
  // word address is paddr[2]; the low two bits are ignored
  // ---------------------------------------------------------------------------
  assign pready     = 1'b1;
  assign min_length = (paddr[2] == REG_MIN_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_len <= MIN_LEN_RESET;
    end else if (psel && penable && pwrite && pready && min_length) begin
      min_len <= pwdata[7:0];
    end
  end

  assign prdata = min_length ? {24'd0, min_len} : 32'd0;

  // input register; stalls only when a final byte waits on a full result register
  ifcc_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_data  (data_byte),
    .in_last  (last_byte),
    .in_stall (in_stall),
    .go       (go),
    .s1_valid (s1_valid),
    .s1_word  (s1_word)
  );

  // per-file tracking: header match, bmp size, trailer detectors and the verdict
  // state clears itself on the word that carries the final byte
  ifcc_track u_track (
    .clk        (clk),
    .rst        (rst),
    .s1_valid   (s1_valid),
    .s1_word    (s1_word),
    .out_free   (out_free),
    .min_length (min_len),
    .go         (go),
    .res_valid  (res_valid),
    .res        (res)
  );

  // result register; a waiting result does not hold up non-final bytes
  ifcc_out_stage u_out_stage (
    .clk         (clk),
    .rst         (rst),
    .res_valid   (res_valid),
    .res         (res),
    .out_free    (out_free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .complete    (complete),
    .format      (format),
    .file_length (file_length)
  );

endmodule
